@@ design/tsp_pkg.sv @@
// Shared types and constants for the TLV stream parser.
package tsp_pkg;

    localparam int MAX_LENGTH_BYTES = 2;

    typedef enum logic [1:0] {
        CLASS_HEADER  = 2'd0,
        CLASS_TAG     = 2'd1,
        CLASS_VALUE   = 2'd2,
        CLASS_DISCARD = 2'd3
    } byte_class_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_TAG_OVF     = 3'd1,
        STATUS_TAG_ZERO    = 3'd2,
        STATUS_LEN_MISSING = 3'd3,
        STATUS_LEN_FORM    = 3'd4,
        STATUS_LEN_OVF     = 3'd5,
        STATUS_VALUE_OVF   = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in_buffer;
    } in_t;

    typedef struct packed {
        byte_class_t byte_class;
        logic [7:0]  out_byte;
        logic        record_done;
        logic [7:0]  tag_size;
        logic [15:0] value_size;
        logic        buffer_done;
        status_t     status;
    } out_t;

endpackage

@@ design/tsp_parse.sv @@
// Per-byte parse state and classification logic.
module tsp_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  tsp_pkg::in_t  item,
    output tsp_pkg::out_t result
);

    typedef enum logic [2:0] {
        PH_TAGLEN = 3'd0,
        PH_TAG    = 3'd1,
        PH_LEN    = 3'd2,
        PH_EXT    = 3'd3,
        PH_VALUE  = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         tag_count_reg, tag_count_next;
    logic [7:0]         tag_left_reg, tag_left_next;
    logic [1:0]         ext_left_reg, ext_left_next;
    logic [15:0]        value_count_reg, value_count_next;
    logic [15:0]        value_left_reg, value_left_next;
    tsp_pkg::status_t   error_reg, error_next;

    tsp_pkg::byte_class_t cls;
    tsp_pkg::status_t     err;
    logic                 done;
    logic [7:0]           b;
    logic                 last;
    logic [6:0]           n;

    assign b    = item.in_byte;
    assign last = item.last_in_buffer;
    assign n    = b[6:0];

    always_comb
    begin
        phase_next       = phase_reg;
        tag_count_next   = tag_count_reg;
        tag_left_next    = tag_left_reg;
        ext_left_next    = ext_left_reg;
        value_count_next = value_count_reg;
        value_left_next  = value_left_reg;
        error_next       = error_reg;
        cls              = tsp_pkg::CLASS_DISCARD;
        err              = tsp_pkg::STATUS_OK;
        done             = 1'b0;
        unique case (phase_reg)
            PH_TAGLEN:
            begin
                cls              = tsp_pkg::CLASS_HEADER;
                tag_count_next   = b;
                tag_left_next    = b;
                ext_left_next    = 2'd0;
                value_count_next = 16'd0;
                value_left_next  = 16'd0;
                if (b == 8'd0)
                    err = tsp_pkg::STATUS_TAG_ZERO;
                else if (last)
                    err = tsp_pkg::STATUS_TAG_OVF;
                else
                    phase_next = PH_TAG;
            end
            PH_TAG:
            begin
                cls           = tsp_pkg::CLASS_TAG;
                tag_left_next = tag_left_reg - 8'd1;
                if (last)
                    err = (tag_left_next != 8'd0) ? tsp_pkg::STATUS_TAG_OVF
                                                  : tsp_pkg::STATUS_LEN_MISSING;
                else if (tag_left_next == 8'd0)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                cls = tsp_pkg::CLASS_HEADER;
                if (!b[7])
                begin
                    value_count_next = {8'd0, b};
                    value_left_next  = {8'd0, b};
                    if (b == 8'd0)
                    begin
                        done       = 1'b1;
                        phase_next = PH_TAGLEN;
                    end
                    else if (last)
                        err = tsp_pkg::STATUS_VALUE_OVF;
                    else
                        phase_next = PH_VALUE;
                end
                else if (n == 7'd0 || n > 7'(tsp_pkg::MAX_LENGTH_BYTES))
                    err = tsp_pkg::STATUS_LEN_FORM;
                else if (last)
                    err = tsp_pkg::STATUS_LEN_OVF;
                else
                begin
                    ext_left_next    = n[1:0];
                    value_count_next = 16'd0;
                    phase_next       = PH_EXT;
                end
            end
            PH_EXT:
            begin
                cls              = tsp_pkg::CLASS_HEADER;
                value_count_next = {value_count_reg[7:0], b};
                ext_left_next    = ext_left_reg - 2'd1;
                if (ext_left_next != 2'd0)
                begin
                    if (last)
                        err = tsp_pkg::STATUS_LEN_OVF;
                end
                else
                begin
                    value_left_next = value_count_next;
                    if (value_count_next == 16'd0)
                    begin
                        done       = 1'b1;
                        phase_next = PH_TAGLEN;
                    end
                    else if (last)
                        err = tsp_pkg::STATUS_VALUE_OVF;
                    else
                        phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                cls             = tsp_pkg::CLASS_VALUE;
                value_left_next = value_left_reg - 16'd1;
                if (value_left_next == 16'd0)
                begin
                    done       = 1'b1;
                    phase_next = PH_TAGLEN;
                end
                else if (last)
                    err = tsp_pkg::STATUS_VALUE_OVF;
            end
            default:
            begin
                cls = tsp_pkg::CLASS_DISCARD;
            end
        endcase
        if (err != tsp_pkg::STATUS_OK)
        begin
            error_next = err;
            phase_next = PH_ERROR;
        end
    end

    always_comb
    begin
        result.byte_class  = cls;
        result.out_byte    = b;
        result.record_done = done;
        result.tag_size    = tag_count_next;
        result.value_size  = value_count_next;
        result.buffer_done = last;
        result.status      = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TAGLEN;
            tag_count_reg   <= 8'd0;
            tag_left_reg    <= 8'd0;
            ext_left_reg    <= 2'd0;
            value_count_reg <= 16'd0;
            value_left_reg  <= 16'd0;
            error_reg       <= tsp_pkg::STATUS_OK;
        end
        else if (advance)
        begin
            if (last)
            begin
                phase_reg       <= PH_TAGLEN;
                tag_count_reg   <= 8'd0;
                tag_left_reg    <= 8'd0;
                ext_left_reg    <= 2'd0;
                value_count_reg <= 16'd0;
                value_left_reg  <= 16'd0;
                error_reg       <= tsp_pkg::STATUS_OK;
            end
            else
            begin
                phase_reg       <= phase_next;
                tag_count_reg   <= tag_count_next;
                tag_left_reg    <= tag_left_next;
                ext_left_reg    <= ext_left_next;
                value_count_reg <= value_count_next;
                value_left_reg  <= value_left_next;
                error_reg       <= error_next;
            end
        end
    end

    a_discard_only_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |-> error_reg != tsp_pkg::STATUS_OK)
        else $error("error phase without an error code");

    a_ok_outside_error: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_ERROR |-> error_reg == tsp_pkg::STATUS_OK)
        else $error("error code set outside error phase");

    a_value_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> value_left_reg != 16'd0)
        else $error("value phase with nothing left");

    a_tag_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAG |-> tag_left_reg != 8'd0)
        else $error("tag phase with nothing left");

endmodule

@@ design/tlv_stream_parser.sv @@
// Top level of the TLV stream parser: input register, parser, result register.
// Takes one buffer byte per clock unless the result side stalls, and returns
// one classified result per byte, in order. A byte is captured in an input
// register, classified against the parser state and written to the result
// register once that register is free; the parser state updates with each
// byte, so a new byte can follow every clock. The input side keeps accepting
// while a result waits, as long as the input register is empty or the result
// register is free or being taken in the same cycle. Status stays 0 until an
// error, then holds that error code and marks bytes as discarded until the
// byte flagged last_in_buffer, after which the parser starts a fresh buffer.
module tlv_stream_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  tsp_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_ready,
    output tsp_pkg::out_t result
);

    logic          stage_valid_reg;
    tsp_pkg::in_t  stage_item_reg;
    logic          result_valid_reg;
    tsp_pkg::out_t result_reg;
    tsp_pkg::out_t parse_result;
    logic          result_free;
    logic          advance;

    assign result_free = !result_valid_reg || result_ready;
    assign advance     = stage_valid_reg && result_free;
    assign item_ready  = !stage_valid_reg || result_free;

    tsp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (stage_item_reg),
        .result  (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                stage_valid_reg <= item_valid;
            if (result_free)
                result_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_item_reg <= item;
        if (advance)
            result_reg <= parse_result;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_done_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.record_done |->
            result_reg.status == tsp_pkg::STATUS_OK)
        else $error("record completed with an error status");

    a_discard_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.byte_class == tsp_pkg::CLASS_DISCARD |->
            result_reg.status != tsp_pkg::STATUS_OK)
        else $error("byte discarded without an error");

    a_tag_has_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.byte_class == tsp_pkg::CLASS_TAG |->
            result_reg.tag_size != 8'd0)
        else $error("tag byte in a record of zero tag length");

    a_value_has_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.byte_class == tsp_pkg::CLASS_VALUE |->
            result_reg.value_size != 16'd0)
        else $error("value byte in a record of zero value length");

endmodule

@@ tb/sv/tlv_stream_parser_tb.sv @@
// Self-checking testbench for tlv_stream_parser: directed and random TLV buffers, input gaps and output stalls.
`timescale 1ns / 1ps

module tlv_stream_parser_tb;

    localparam int ITEM_TARGET  = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int FEED_SIDE    = 0;
    localparam int SINK_SIDE    = 1;

    typedef enum logic [2:0] {
        SEEK_TAGLEN = 3'd0,
        IN_TAG      = 3'd1,
        IN_LEN      = 3'd2,
        IN_EXT      = 3'd3,
        IN_VALUE    = 3'd4,
        SKIPPING    = 3'd5
    } parse_phase_t;

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           item_valid   = 1'b0;
    logic           item_ready;
    tsp_pkg::in_t   item         = '0;
    logic           result_valid;
    logic           result_ready = 1'b0;
    tsp_pkg::out_t  result;

    tsp_pkg::in_t   byte_feed[$];
    tsp_pkg::out_t  predicted_results[$];
    logic [7:0]     buf_q[$];

    parse_phase_t     pm_phase;
    logic [7:0]       pm_tag_count;
    logic [7:0]       pm_tag_left;
    logic [1:0]       pm_ext_left;
    logic [15:0]      pm_value_count;
    logic [15:0]      pm_value_left;
    tsp_pkg::status_t pm_status;

    int calm_left[2];
    int feed_gap;
    int sink_stall;
    int idle_cycles;
    int mismatches;
    int results_checked;
    int buffers_seen;
    int records_seen;
    int error_buffers;

    tlv_stream_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    function automatic void clear_parse_state();
        pm_phase       = SEEK_TAGLEN;
        pm_tag_count   = 8'd0;
        pm_tag_left    = 8'd0;
        pm_ext_left    = 2'd0;
        pm_value_count = 16'd0;
        pm_value_left  = 16'd0;
        pm_status      = tsp_pkg::STATUS_OK;
    endfunction

    function automatic tsp_pkg::out_t classify_byte(tsp_pkg::in_t it);
        logic [7:0]           b;
        logic                 last;
        logic [6:0]           n;
        tsp_pkg::byte_class_t cls;
        tsp_pkg::status_t     err;
        logic                 done;
        logic                 len_complete;
        tsp_pkg::out_t        r;
        b            = it.in_byte;
        last         = it.last_in_buffer;
        cls          = tsp_pkg::CLASS_DISCARD;
        err          = tsp_pkg::STATUS_OK;
        done         = 1'b0;
        len_complete = 1'b0;
        case (pm_phase)
            SEEK_TAGLEN:
            begin
                cls            = tsp_pkg::CLASS_HEADER;
                pm_tag_count   = b;
                pm_tag_left    = b;
                pm_ext_left    = 2'd0;
                pm_value_count = 16'd0;
                pm_value_left  = 16'd0;
                if (b == 8'd0)
                    err = tsp_pkg::STATUS_TAG_ZERO;
                else if (last)
                    err = tsp_pkg::STATUS_TAG_OVF;
                else
                    pm_phase = IN_TAG;
            end
            IN_TAG:
            begin
                cls         = tsp_pkg::CLASS_TAG;
                pm_tag_left = pm_tag_left - 8'd1;
                if (last)
                    err = (pm_tag_left != 8'd0) ? tsp_pkg::STATUS_TAG_OVF
                                                : tsp_pkg::STATUS_LEN_MISSING;
                else if (pm_tag_left == 8'd0)
                    pm_phase = IN_LEN;
            end
            IN_LEN:
            begin
                cls = tsp_pkg::CLASS_HEADER;
                if (b <= 8'h7F)
                begin
                    pm_value_count = {8'd0, b};
                    len_complete   = 1'b1;
                end
                else
                begin
                    n = b[6:0];
                    if (n == 7'd0 || n > 7'(tsp_pkg::MAX_LENGTH_BYTES))
                        err = tsp_pkg::STATUS_LEN_FORM;
                    else if (last)
                        err = tsp_pkg::STATUS_LEN_OVF;
                    else
                    begin
                        pm_ext_left    = n[1:0];
                        pm_value_count = 16'd0;
                        pm_phase       = IN_EXT;
                    end
                end
            end
            IN_EXT:
            begin
                cls            = tsp_pkg::CLASS_HEADER;
                pm_value_count = {pm_value_count[7:0], b};
                pm_ext_left    = pm_ext_left - 2'd1;
                if (pm_ext_left != 2'd0)
                begin
                    if (last)
                        err = tsp_pkg::STATUS_LEN_OVF;
                end
                else
                    len_complete = 1'b1;
            end
            IN_VALUE:
            begin
                cls           = tsp_pkg::CLASS_VALUE;
                pm_value_left = pm_value_left - 16'd1;
                if (pm_value_left == 16'd0)
                begin
                    done     = 1'b1;
                    pm_phase = SEEK_TAGLEN;
                end
                else if (last)
                    err = tsp_pkg::STATUS_VALUE_OVF;
            end
            default:
                cls = tsp_pkg::CLASS_DISCARD;
        endcase
        if (len_complete)
        begin
            pm_value_left = pm_value_count;
            if (pm_value_count == 16'd0)
            begin
                done     = 1'b1;
                pm_phase = SEEK_TAGLEN;
            end
            else if (last)
                err = tsp_pkg::STATUS_VALUE_OVF;
            else
                pm_phase = IN_VALUE;
        end
        if (err != tsp_pkg::STATUS_OK)
        begin
            pm_status = err;
            pm_phase  = SKIPPING;
        end
        r.byte_class  = cls;
        r.out_byte    = b;
        r.record_done = done;
        r.tag_size    = pm_tag_count;
        r.value_size  = pm_value_count;
        r.buffer_done = last;
        r.status      = pm_status;
        if (last)
            clear_parse_state();
        return r;
    endfunction

    function automatic int draw_gap(input int side);
        int r;
        if (calm_left[side] > 0)
        begin
            calm_left[side] = calm_left[side] - 1;
            return 0;
        end
        if ($urandom_range(0, 63) == 0)
            calm_left[side] = $urandom_range(20, 80);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic string show(tsp_pkg::out_t r);
        return $sformatf("class=%0d byte=%h done=%b tag=%0d value=%0d last=%b status=%0d",
                         r.byte_class, r.out_byte, r.record_done, r.tag_size,
                         r.value_size, r.buffer_done, r.status);
    endfunction

    task automatic build_record(input int tag_len, input int val_len, input int form,
                                input int val_cap);
        logic [15:0] vl;
        vl = val_len[15:0];
        buf_q.push_back(tag_len[7:0]);
        repeat (tag_len) buf_q.push_back(8'($urandom_range(0, 255)));
        case (form)
            0: buf_q.push_back(vl[7:0]);
            1:
            begin
                buf_q.push_back(8'h81);
                buf_q.push_back(vl[7:0]);
            end
            default:
            begin
                buf_q.push_back(8'h82);
                buf_q.push_back(vl[15:8]);
                buf_q.push_back(vl[7:0]);
            end
        endcase
        repeat ((val_len < val_cap) ? val_len : val_cap)
            buf_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic random_record();
        int tl;
        int form;
        int vl;
        tl   = ($urandom_range(0, 39) == 0) ? 255 : $urandom_range(1, 6);
        form = $urandom_range(0, 2);
        case (form)
            0: vl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
            1: vl = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 255) : $urandom_range(0, 8);
            default: vl = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 600)
                                                       : $urandom_range(0, 8);
        endcase
        build_record(tl, vl, form, 1 << 16);
    endtask

    task automatic flush_buffer(input int keep);
        tsp_pkg::in_t x;
        for (int i = 0; i < keep; i++)
        begin
            x.in_byte        = buf_q[i];
            x.last_in_buffer = (i == keep - 1);
            byte_feed.push_back(x);
        end
        buf_q.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            feed_gap   = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predicted_results.push_back(classify_byte(item));
                feed_gap = draw_gap(FEED_SIDE);
            end
            if (item_valid && !item_ready)
                ;
            else if (feed_gap > 0)
            begin
                feed_gap = feed_gap - 1;
                item_valid <= 1'b0;
            end
            else if (byte_feed.size() > 0)
            begin
                item       <= byte_feed.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        tsp_pkg::out_t exp;
        logic bad;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            sink_stall   = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_checked++;
                if (result.buffer_done)
                begin
                    buffers_seen++;
                    if (result.status != tsp_pkg::STATUS_OK)
                        error_buffers++;
                end
                if (result.record_done)
                    records_seen++;
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result at %0t: %s", $realtime, show(result));
                end
                else
                begin
                    exp = predicted_results.pop_front();
                    bad = (result.byte_class  !== exp.byte_class)  ||
                          (result.out_byte    !== exp.out_byte)    ||
                          (result.record_done !== exp.record_done) ||
                          (result.tag_size    !== exp.tag_size)    ||
                          (result.value_size  !== exp.value_size)  ||
                          (result.buffer_done !== exp.buffer_done) ||
                          (result.status      !== exp.status);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, show(exp), show(result));
                    end
                end
                sink_stall = draw_gap(SINK_SIDE);
            end
            else if (sink_stall > 0)
                sink_stall = sink_stall - 1;
            result_ready <= (sink_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, predicted_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int nrec;
        int tl;
        int bad_len;
        clear_parse_state();

        // zero tag length, then a discarded byte
        buf_q.push_back(8'h00);
        buf_q.push_back(8'hFF);
        flush_buffer(buf_q.size());
        // nonzero tag length as the last byte
        buf_q.push_back(8'hFF);
        flush_buffer(buf_q.size());
        // cut inside the tag
        buf_q.push_back(8'h02);
        buf_q.push_back(8'hAA);
        flush_buffer(buf_q.size());
        // cut after the final tag byte
        buf_q.push_back(8'h01);
        buf_q.push_back(8'h55);
        flush_buffer(buf_q.size());
        // indefinite length form
        buf_q.push_back(8'h01);
        buf_q.push_back(8'h11);
        buf_q.push_back(8'h80);
        buf_q.push_back(8'h22);
        flush_buffer(buf_q.size());
        // long form cut at its first byte
        buf_q.push_back(8'h01);
        buf_q.push_back(8'h11);
        buf_q.push_back(8'h81);
        flush_buffer(buf_q.size());
        // cut between extension bytes
        buf_q.push_back(8'h01);
        buf_q.push_back(8'h11);
        buf_q.push_back(8'h82);
        buf_q.push_back(8'hFF);
        flush_buffer(buf_q.size());
        // cut inside the value
        buf_q.push_back(8'h01);
        buf_q.push_back(8'h11);
        buf_q.push_back(8'h02);
        buf_q.push_back(8'hAA);
        flush_buffer(buf_q.size());
        // zero value length completes on the last byte
        buf_q.push_back(8'h01);
        buf_q.push_back(8'hFF);
        buf_q.push_back(8'h00);
        flush_buffer(buf_q.size());

        while (byte_feed.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                nrec = $urandom_range(1, 4);
                repeat (nrec) random_record();
                flush_buffer(buf_q.size());
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 1) == 1)
                    random_record();
                if ($urandom_range(0, 1) == 1)
                    build_record($urandom_range(1, 4), $urandom_range(0, 65535), 2, 12);
                else
                    random_record();
                flush_buffer($urandom_range(1, buf_q.size()));
            end
            else if (kind < 95)
            begin
                if ($urandom_range(0, 1) == 1)
                    random_record();
                if ($urandom_range(0, 2) == 0)
                    buf_q.push_back(8'h00);
                else
                begin
                    tl = $urandom_range(1, 4);
                    buf_q.push_back(tl[7:0]);
                    repeat (tl) buf_q.push_back(8'($urandom_range(0, 255)));
                    bad_len = ($urandom_range(0, 2) == 0) ? 8'h80 : $urandom_range(8'h83, 8'hFF);
                    buf_q.push_back(bad_len[7:0]);
                end
                repeat ($urandom_range(0, 5)) buf_q.push_back(8'($urandom_range(0, 255)));
                flush_buffer(buf_q.size());
            end
            else
            begin
                repeat ($urandom_range(1, 10)) buf_q.push_back(8'($urandom_range(0, 255)));
                flush_buffer(buf_q.size());
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (byte_feed.size() != 0 || item_valid)
            @(negedge clk);
        while (predicted_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d results in %0d buffers", results_checked, buffers_seen);
        $display("%0d records completed, %0d buffers ended in error",
                 records_seen, error_buffers);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
